FILE: rtl/pidc_pkg.sv
// Package for the clamped PID controller: widths, state codes and a saturation helper.
`default_nettype none

package pidc_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_WIDTH = 32;

   localparam int ERR_W  = DATA_WIDTH + 1;
   localparam int SUM_W  = ((DATA_WIDTH + FRAC_BITS) > 62) ? 62 : (DATA_WIDTH + FRAC_BITS);
   localparam int DER_W  = ((DATA_WIDTH + 2 + FRAC_BITS) > 62) ? 62
                           : (DATA_WIDTH + 2 + FRAC_BITS);
   localparam int TERM_W = 61;
   localparam int TOT_W  = TERM_W + 2;
   localparam int NUM_W  = ERR_W + 1;
   localparam int DVD_W  = DATA_WIDTH + 1 + FRAC_BITS;
   localparam int QT_W   = DVD_W + 1;
   localparam int MC_W   = DER_W;
   localparam int MP_W   = DATA_WIDTH;
   localparam int PROD_W = MC_W + MP_W;
   localparam int ADD_W  = PROD_W + 1;
   localparam int RES_W  = ADD_W - FRAC_BITS;
   localparam int EXT_A  = (RES_W > QT_W) ? RES_W : QT_W;
   localparam int EXT_W  = ((EXT_A > 62) ? EXT_A : 62) + 1;
   localparam int CNT_W  = $clog2(DVD_W);

   localparam int REQ_TDATA_W = ((2 * DATA_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ((DATA_WIDTH + 7) / 8) * 8;
   localparam int CSR_IDX_W   = 3;

   localparam logic [EXT_W-1:0] LIM_SUM  = EXT_W'(1) << (SUM_W - 1);
   localparam logic [EXT_W-1:0] LIM_DER  = EXT_W'(1) << (DER_W - 1);
   localparam logic [EXT_W-1:0] LIM_TERM = EXT_W'(1) << (TERM_W - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STEP_TIME = 3'd0,
      REG_DRIVE_MAX = 3'd1,
      REG_DRIVE_MIN = 3'd2,
      REG_GAIN_P    = 3'd3,
      REG_GAIN_D    = 3'd4,
      REG_GAIN_I    = 3'd5
   } csr_idx_type;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_MUL   = 8'b0000_0010,
      S_MRND  = 8'b0000_0100,
      S_MSAT  = 8'b0000_1000,
      S_DIV   = 8'b0001_0000,
      S_DRND  = 8'b0010_0000,
      S_DINC  = 8'b0100_0000,
      S_CLAMP = 8'b1000_0000
   } state_type;

   typedef enum logic [3:0] {
      PH_INC = 4'b0001,
      PH_P   = 4'b0010,
      PH_I   = 4'b0100,
      PH_D   = 4'b1000
   } phase_type;

   // signed value from sign and magnitude, limited to -lim..lim-1
   function automatic logic signed [EXT_W-1:0] sat_mag(input logic neg,
                                                      input logic [EXT_W-1:0] m,
                                                      input logic [EXT_W-1:0] lim);
      logic [EXT_W-1:0] v;
      if (m >= lim) begin
         v = neg ? (~lim + EXT_W'(1)) : (lim - EXT_W'(1));
      end else begin
         v = neg ? (~m + EXT_W'(1)) : m;
      end
      return signed'(v);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/pid_controller_clamped_unit.sv
// Top level of the clamped PID controller with its shared add/subtract sequencer.
// Signed fixed-point PID regulator. Each accepted req transaction carries a target
// and a measured value; one rsp transaction returns the limited drive and a flag in
// tuser when drive_max or drive_min acted. One adder, shared by a shift-add multiplier
// and a restoring divider, does all long arithmetic: the integral increment, the
// three gain products and the derivative division. An item waits in the clamp step
// only while a previous result waits on rsp_tready. req_tready is high only between
// items. Any csr write to registers 0..5 clears the integral and the previous error;
// other indexes are ignored.
`default_nettype none

module pid_controller_clamped_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [pidc_pkg::REQ_TDATA_W-1:0]    req_tdata,   // target, measured
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pidc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // drive
   output logic                                rsp_tuser,   // clamped
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pidc_pkg::CSR_IDX_W-1:0]      csr_addr,
   input  logic [pidc_pkg::DATA_WIDTH-1:0]     csr_wdata
);
   import pidc_pkg::*;

   state_type                   state_ff, state_in;
   phase_type                   phase_ff, phase_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [ADD_W-1:0]            acc_ff, acc_in;
   logic [MC_W-1:0]             mcand_ff, mcand_in;
   logic [MP_W-1:0]             mplr_ff, mplr_in;
   logic [DVD_W-1:0]            dvd_ff, dvd_in;
   logic                        neg_ff, neg_in;
   logic                        rnd_ff, rnd_in;
   logic signed [ERR_W-1:0]     err_ff, err_in;
   logic signed [DER_W-1:0]     deriv_ff, deriv_in;
   logic signed [TOT_W-1:0]     total_ff, total_in;
   logic signed [SUM_W-1:0]     error_sum_ff, error_sum_in;
   logic signed [ERR_W-1:0]     last_error_ff, last_error_in;
   logic [DATA_WIDTH-1:0]       step_time_ff, step_time_in;
   logic signed [DATA_WIDTH-1:0] drive_max_ff, drive_max_in;
   logic signed [DATA_WIDTH-1:0] drive_min_ff, drive_min_in;
   logic signed [DATA_WIDTH-1:0] gain_p_ff, gain_p_in;
   logic signed [DATA_WIDTH-1:0] gain_d_ff, gain_d_in;
   logic signed [DATA_WIDTH-1:0] gain_i_ff, gain_i_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]       drive_ff, drive_in;
   logic                        clamped_ff, clamped_in;

   // shared adder
   logic [ADD_W-1:0]            add_a, add_b, add_sum;
   logic                        add_c;

   logic signed [DATA_WIDTH-1:0] tgt, meas;
   logic signed [ERR_W-1:0]     err_new;
   logic [ERR_W-1:0]            err_new_mag, err_mag;
   logic [DATA_WIDTH-1:0]       dt_eff;
   logic signed [NUM_W-1:0]     num;
   logic [NUM_W-1:0]            num_mag;
   logic [SUM_W-1:0]            esum_mag;
   logic [DER_W-1:0]            deriv_mag;
   logic [DATA_WIDTH-1:0]       gp_mag, gi_mag, gd_mag;
   logic [EXT_W-1:0]            res_lim;
   logic signed [EXT_W-1:0]     prod_sat, quot_sat;
   logic signed [SUM_W-1:0]     inc_val;
   logic signed [TERM_W-1:0]    term_val;
   logic [SUM_W:0]              esum_add;
   logic signed [TOT_W-1:0]     total_add;
   logic                        over_max, under_min, cfg_hit;

   assign tgt         = signed'(req_tdata[DATA_WIDTH-1:0]);
   assign meas        = signed'(req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
   assign err_new     = ERR_W'(tgt) - ERR_W'(meas);
   assign err_new_mag = err_new[ERR_W-1] ? (~err_new + ERR_W'(1)) : err_new;
   assign err_mag     = err_ff[ERR_W-1] ? (~err_ff + ERR_W'(1)) : err_ff;
   assign dt_eff      = (step_time_ff == '0) ? DATA_WIDTH'(1) : step_time_ff;
   assign num         = NUM_W'(err_ff) - NUM_W'(last_error_ff);
   assign num_mag     = num[NUM_W-1] ? (~num + NUM_W'(1)) : num;
   assign esum_mag    = error_sum_ff[SUM_W-1] ? (~error_sum_ff + SUM_W'(1)) : error_sum_ff;
   assign deriv_mag   = deriv_ff[DER_W-1] ? (~deriv_ff + DER_W'(1)) : deriv_ff;
   assign gp_mag      = gain_p_ff[DATA_WIDTH-1] ? (~gain_p_ff + DATA_WIDTH'(1)) : gain_p_ff;
   assign gi_mag      = gain_i_ff[DATA_WIDTH-1] ? (~gain_i_ff + DATA_WIDTH'(1)) : gain_i_ff;
   assign gd_mag      = gain_d_ff[DATA_WIDTH-1] ? (~gain_d_ff + DATA_WIDTH'(1)) : gain_d_ff;

   assign add_sum = add_a + add_b + ADD_W'(add_c);

   always_comb begin
      add_a = '0;
      add_b = '0;
      add_c = 1'b0;
      case (state_ff)
         S_MUL: begin
            add_a = {acc_ff[ADD_W-2:0], 1'b0};
            add_b = mplr_ff[MP_W-1] ? ADD_W'(mcand_ff) : '0;
         end
         S_MRND: begin
            add_a = acc_ff;
            add_b = ADD_W'(1) << (FRAC_BITS - 1);
         end
         S_DIV: begin
            add_a = ADD_W'({acc_ff[DATA_WIDTH-1:0], dvd_ff[DVD_W-1]});
            add_b = ~ADD_W'(dt_eff);
            add_c = 1'b1;
         end
         S_DRND: begin
            add_a = ADD_W'({acc_ff[DATA_WIDTH-1:0], 1'b0});
            add_b = ~ADD_W'(dt_eff);
            add_c = 1'b1;
         end
         S_DINC: begin
            add_a = ADD_W'(dvd_ff);
            add_c = rnd_ff;
         end
         default: begin
            add_a = '0;
         end
      endcase
   end

   assign res_lim   = (phase_ff == PH_INC) ? LIM_SUM : LIM_TERM;
   assign prod_sat  = sat_mag(neg_ff, EXT_W'(acc_ff[ADD_W-1:FRAC_BITS]), res_lim);
   assign quot_sat  = sat_mag(neg_ff, EXT_W'(add_sum[QT_W-1:0]), LIM_DER);
   assign inc_val   = prod_sat[SUM_W-1:0];
   assign term_val  = prod_sat[TERM_W-1:0];
   assign esum_add  = (SUM_W + 1)'(error_sum_ff) + (SUM_W + 1)'(inc_val);
   assign total_add = total_ff + TOT_W'(term_val);
   assign over_max  = total_ff > TOT_W'(drive_max_ff);
   assign under_min = total_ff < TOT_W'(drive_min_ff);

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplr_in       = mplr_ff;
      dvd_in        = dvd_ff;
      neg_in        = neg_ff;
      rnd_in        = rnd_ff;
      err_in        = err_ff;
      deriv_in      = deriv_ff;
      total_in      = total_ff;
      error_sum_in  = error_sum_ff;
      last_error_in = last_error_ff;
      drive_in      = drive_ff;
      clamped_in    = clamped_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               err_in   = err_new;
               mcand_in = MC_W'(err_new_mag);
               mplr_in  = dt_eff;
               neg_in   = err_new[ERR_W-1];
               acc_in   = '0;
               cnt_in   = '0;
               phase_in = PH_INC;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            acc_in  = add_sum;
            mplr_in = {mplr_ff[MP_W-2:0], 1'b0};
            cnt_in  = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_W'(MP_W - 1)) begin
               state_in = S_MRND;
            end
         end
         S_MRND: begin
            acc_in   = add_sum;
            state_in = S_MSAT;
         end
         S_MSAT: begin
            acc_in = '0;
            cnt_in = '0;
            case (phase_ff)
               PH_INC: begin
                  if (esum_add[SUM_W] != esum_add[SUM_W-1]) begin
                     error_sum_in = esum_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                    : {1'b0, {(SUM_W-1){1'b1}}};
                  end else begin
                     error_sum_in = esum_add[SUM_W-1:0];
                  end
                  dvd_in   = {num_mag[NUM_W-2:0], {FRAC_BITS{1'b0}}};
                  neg_in   = num[NUM_W-1];
                  state_in = S_DIV;
               end
               PH_P: begin
                  total_in = TOT_W'(term_val);
                  mcand_in = MC_W'(esum_mag);
                  mplr_in  = gi_mag;
                  neg_in   = gain_i_ff[DATA_WIDTH-1] ^ error_sum_ff[SUM_W-1];
                  phase_in = PH_I;
                  state_in = S_MUL;
               end
               PH_I: begin
                  total_in = total_add;
                  mcand_in = MC_W'(deriv_mag);
                  mplr_in  = gd_mag;
                  neg_in   = gain_d_ff[DATA_WIDTH-1] ^ deriv_ff[DER_W-1];
                  phase_in = PH_D;
                  state_in = S_MUL;
               end
               PH_D: begin
                  total_in = total_add;
                  state_in = S_CLAMP;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DIV: begin
            acc_in = add_sum[ADD_W-1] ? add_a : add_sum;
            dvd_in = {dvd_ff[DVD_W-2:0], ~add_sum[ADD_W-1]};
            cnt_in = CNT_W'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_W'(DVD_W - 1)) begin
               state_in = S_DRND;
            end
         end
         S_DRND: begin
            rnd_in   = ~add_sum[ADD_W-1];
            state_in = S_DINC;
         end
         S_DINC: begin
            deriv_in = quot_sat[DER_W-1:0];
            mcand_in = MC_W'(err_mag);
            mplr_in  = gp_mag;
            neg_in   = gain_p_ff[DATA_WIDTH-1] ^ err_ff[ERR_W-1];
            acc_in   = '0;
            cnt_in   = '0;
            phase_in = PH_P;
            state_in = S_MUL;
         end
         S_CLAMP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               if (over_max) begin
                  drive_in   = drive_max_ff;
                  clamped_in = 1'b1;
               end else if (under_min) begin
                  drive_in   = drive_min_ff;
                  clamped_in = 1'b1;
               end else begin
                  drive_in   = total_ff[DATA_WIDTH-1:0];
                  clamped_in = 1'b0;
               end
               rsp_valid_in  = 1'b1;
               last_error_in = err_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      step_time_in = step_time_ff;
      drive_max_in = drive_max_ff;
      drive_min_in = drive_min_ff;
      gain_p_in    = gain_p_ff;
      gain_d_in    = gain_d_ff;
      gain_i_in    = gain_i_ff;
      cfg_hit      = 1'b0;
      if (csr_valid) begin
         cfg_hit = 1'b1;
         case (csr_idx_type'(csr_addr))
            REG_STEP_TIME: step_time_in = csr_wdata;
            REG_DRIVE_MAX: drive_max_in = signed'(csr_wdata);
            REG_DRIVE_MIN: drive_min_in = signed'(csr_wdata);
            REG_GAIN_P:    gain_p_in    = signed'(csr_wdata);
            REG_GAIN_D:    gain_d_in    = signed'(csr_wdata);
            REG_GAIN_I:    gain_i_in    = signed'(csr_wdata);
            default:       cfg_hit      = 1'b0;
         endcase
      end
      if (cfg_hit) begin
         error_sum_in  = '0;
         last_error_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_INC;
         rsp_valid_ff  <= 1'b0;
         error_sum_ff  <= '0;
         last_error_ff <= '0;
         step_time_ff  <= DATA_WIDTH'(1) << FRAC_BITS;
         drive_max_ff  <= {1'b0, {(DATA_WIDTH-1){1'b1}}};
         drive_min_ff  <= {1'b1, {(DATA_WIDTH-1){1'b0}}};
         gain_p_ff     <= '0;
         gain_d_ff     <= '0;
         gain_i_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
         error_sum_ff  <= error_sum_in;
         last_error_ff <= last_error_in;
         step_time_ff  <= step_time_in;
         drive_max_ff  <= drive_max_in;
         drive_min_ff  <= drive_min_in;
         gain_p_ff     <= gain_p_in;
         gain_d_ff     <= gain_d_in;
         gain_i_ff     <= gain_i_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      acc_ff     <= acc_in;
      mcand_ff   <= mcand_in;
      mplr_ff    <= mplr_in;
      dvd_ff     <= dvd_in;
      neg_ff     <= neg_in;
      rnd_ff     <= rnd_in;
      err_ff     <= err_in;
      deriv_ff   <= deriv_in;
      total_ff   <= total_in;
      drive_ff   <= drive_in;
      clamped_ff <= clamped_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(drive_ff);
   assign rsp_tuser  = clamped_ff;
   assign csr_ready  = 1'b1;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("block ready right after accepting a transaction");

   a_result_from_clamp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff == S_CLAMP))
      else $error("result issued outside the clamp step");

   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (cnt_ff < CNT_W'(MP_W)))
      else $error("multiply step count overran");

endmodule

`default_nettype wire

FILE: bench/pid_controller_clamped_unit_test.sv
// Self-checking testbench for the clamped PID controller: directed table plus random phases.
`timescale 1ns / 1ps

module pid_controller_clamped_unit_test;
   import pidc_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;

   localparam logic [31:0] POS_FULL  = 32'h7FFF_FFFF;
   localparam logic [31:0] NEG_FULL  = 32'h8000_0000;
   localparam logic [31:0] UNITY     = 32'h0001_0000;
   localparam logic [31:0] NEG_UNITY = 32'hFFFF_0000;

   localparam logic ROW_WRITE  = 1'b1;
   localparam logic ROW_SAMPLE = 1'b0;

   localparam int PHASES         = 10;
   localparam int PHASE_ITEMS    = 53;
   localparam int CALM_PHASE     = 4;
   localparam int SQUEEZE_PHASE  = 6;
   localparam int HOLD_CYCLES    = 800;
   localparam int SETTLE_CYCLES  = 250;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int IDLE_PCT       = 38;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] drive;
      logic                  clamped;
   } control_out_t;

   typedef struct packed {
      logic         pinned;
      control_out_t value;
   } pin_t;

   typedef struct packed {
      logic                  is_write;
      logic [CSR_IDX_W-1:0]  addr;
      logic [DATA_WIDTH-1:0] value;
      logic [DATA_WIDTH-1:0] target;
      logic [DATA_WIDTH-1:0] measured;
      logic                  pinned;
      logic [DATA_WIDTH-1:0] drive;
      logic                  clamped;
   } step_row_t;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_W-1:0]     req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]     rsp_tdata;
   logic                       rsp_tuser;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_addr   = '0;
   logic [DATA_WIDTH-1:0]      csr_wdata  = '0;

   // controller model state
   logic [DATA_WIDTH-1:0]        cfg_step = UNITY;
   logic signed [DATA_WIDTH-1:0] cfg_max  = POS_FULL;
   logic signed [DATA_WIDTH-1:0] cfg_min  = NEG_FULL;
   logic signed [DATA_WIDTH-1:0] cfg_kp   = '0;
   logic signed [DATA_WIDTH-1:0] cfg_kd   = '0;
   logic signed [DATA_WIDTH-1:0] cfg_ki   = '0;
   longint                       integral_acc = 0;
   longint                       prior_error  = 0;

   control_out_t pending_q [$];
   pin_t         pinned_q  [$];

   int  sent_count    = 0;
   int  checked_count = 0;
   int  mismatches    = 0;
   int  write_count   = 0;
   int  limited_count = 0;
   int  quiet_cycles  = 0;
   bit  idle_on       = 1'b1;
   bit  hold_pending  = 1'b0;

   step_row_t directed_rows [0:41] = '{
      // after reset: zero gains give zero drive
      '{ROW_SAMPLE, 3'd0, '0, POS_FULL, NEG_FULL, 1'b1, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, NEG_FULL, POS_FULL, 1'b1, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, '0, '0, 1'b1, '0, 1'b0},
      // crossed limits: zero sum is above drive_max
      '{ROW_WRITE, REG_DRIVE_MAX, NEG_UNITY, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_WRITE, REG_DRIVE_MIN, UNITY, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, UNITY, '0, 1'b1, NEG_UNITY, 1'b1},
      '{ROW_WRITE, REG_DRIVE_MAX, '0, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_WRITE, REG_DRIVE_MIN, '0, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, 32'd1234, -32'sd77, 1'b1, '0, 1'b0},
      '{ROW_WRITE, REG_DRIVE_MAX, POS_FULL, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_WRITE, REG_DRIVE_MIN, NEG_FULL, '0, '0, 1'b0, '0, 1'b0},
      // full proportional gain on full error hits the limits
      '{ROW_WRITE, REG_GAIN_P, POS_FULL, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, POS_FULL, NEG_FULL, 1'b1, POS_FULL, 1'b1},
      '{ROW_SAMPLE, 3'd0, '0, NEG_FULL, POS_FULL, 1'b1, NEG_FULL, 1'b1},
      '{ROW_WRITE, REG_GAIN_P, UNITY, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, 32'h0005_0000, 32'h0002_0000, 1'b1, 32'h0003_0000, 1'b0},
      // integral saturation with the largest dt
      '{ROW_WRITE, REG_GAIN_I, POS_FULL, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_WRITE, REG_STEP_TIME, 32'hFFFF_FFFF, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, POS_FULL, NEG_FULL, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, POS_FULL, NEG_FULL, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, POS_FULL, NEG_FULL, 1'b0, '0, 1'b0},
      // unknown index must not clear the integral
      '{ROW_WRITE, REG_SPARE_A, 32'h1234_5678, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, NEG_FULL, POS_FULL, 1'b0, '0, 1'b0},
      // zero dt behaves as one LSB, derivative saturates
      '{ROW_WRITE, REG_STEP_TIME, '0, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_WRITE, REG_GAIN_D, POS_FULL, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, POS_FULL, NEG_FULL, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, NEG_FULL, POS_FULL, 1'b0, '0, 1'b0},
      '{ROW_WRITE, REG_SPARE_B, '0, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, 32'h10, 32'h20, 1'b0, '0, 1'b0},
      '{ROW_WRITE, REG_GAIN_P, NEG_FULL, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_WRITE, REG_GAIN_I, NEG_FULL, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_WRITE, REG_GAIN_D, NEG_FULL, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_WRITE, REG_STEP_TIME, 32'd1, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, POS_FULL, NEG_FULL, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, NEG_FULL, POS_FULL, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, '0, '0, 1'b0, '0, 1'b0},
      // moderate loop, rounding of small products
      '{ROW_WRITE, REG_STEP_TIME, UNITY, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_WRITE, REG_GAIN_D, 32'h0000_8000, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_WRITE, REG_GAIN_I, 32'h0000_0100, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_WRITE, REG_GAIN_P, 32'hFFFF_8000, '0, '0, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, 32'h0003_0000, 32'h0001_0000, 1'b0, '0, 1'b0},
      '{ROW_SAMPLE, 3'd0, '0, 32'h0001_0000, 32'h0003_0000, 1'b0, '0, 1'b0}
   };

   pid_controller_clamped_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint limit_to(longint v, int w);
      longint bound;
      bound = longint'(1) << (w - 1);
      if (v > bound - 1) return bound - 1;
      if (v < -bound) return -bound;
      return v;
   endfunction

   function automatic longint from_magnitude(logic neg, logic [127:0] m, int w);
      logic [127:0] top;
      top = 128'(1) << (w - 1);
      if (m >= top) return neg ? -longint'(top) : longint'(top) - 1;
      return neg ? -longint'(m) : longint'(m);
   endfunction

   // (a*b) >> FRAC_BITS, round half away from zero, saturate to w bits
   function automatic longint fixed_mul(longint a, longint b, int w);
      logic [127:0] ma, mb, prod;
      ma = 128'(a < 0 ? -a : a);
      mb = 128'(b < 0 ? -b : b);
      prod = ma * mb + (128'(1) << (FRAC_BITS - 1));
      return from_magnitude((a < 0) != (b < 0), prod >> FRAC_BITS, w);
   endfunction

   // (num << FRAC_BITS) / den, round half away from zero, saturate to w bits
   function automatic longint fixed_div(longint num, longint den, int w);
      logic [127:0] n, d, q, r;
      n = 128'(num < 0 ? -num : num) << FRAC_BITS;
      d = 128'(den);
      q = n / d;
      r = n % d;
      if ((r << 1) >= d) q = q + 1;
      return from_magnitude(num < 0, q, w);
   endfunction

   function automatic control_out_t regulate(logic signed [DATA_WIDTH-1:0] setpoint,
                                             logic signed [DATA_WIDTH-1:0] process);
      longint       err, dt, deriv, total;
      control_out_t res;
      err = longint'(setpoint) - longint'(process);
      dt = (cfg_step == '0) ? longint'(1) : longint'(cfg_step);
      integral_acc = limit_to(integral_acc + fixed_mul(err, dt, SUM_W), SUM_W);
      deriv = fixed_div(err - prior_error, dt, DER_W);
      total = fixed_mul(cfg_kp, err, TERM_W) + fixed_mul(cfg_ki, integral_acc, TERM_W)
            + fixed_mul(cfg_kd, deriv, TERM_W);
      res.clamped = 1'b0;
      if (total > longint'(cfg_max)) begin
         total = cfg_max;
         res.clamped = 1'b1;
      end else if (total < longint'(cfg_min)) begin
         total = cfg_min;
         res.clamped = 1'b1;
      end
      prior_error = limit_to(err, ERR_W);
      res.drive = DATA_WIDTH'(total);
      return res;
   endfunction

   function automatic void apply_register(logic [CSR_IDX_W-1:0] idx,
                                          logic [DATA_WIDTH-1:0] value);
      case (idx)
         REG_STEP_TIME: cfg_step = value;
         REG_DRIVE_MAX: cfg_max  = value;
         REG_DRIVE_MIN: cfg_min  = value;
         REG_GAIN_P:    cfg_kp   = value;
         REG_GAIN_D:    cfg_kd   = value;
         REG_GAIN_I:    cfg_ki   = value;
         default:       return;
      endcase
      integral_acc = 0;
      prior_error  = 0;
   endfunction

   function automatic logic [31:0] spread(int unsigned span);
      return 32'($urandom_range(0, 2 * span)) - 32'(span);
   endfunction

   function automatic logic [31:0] register_value(logic [CSR_IDX_W-1:0] idx);
      case (idx)
         REG_STEP_TIME:
            case ($urandom_range(9))
               0:       return '0;
               1:       return '1;
               2:       return 32'd1;
               3:       return $urandom;
               default: return $urandom_range(65, 65536);
            endcase
         REG_DRIVE_MAX:
            case ($urandom_range(7))
               0:       return POS_FULL;
               1:       return NEG_FULL;
               2:       return $urandom;
               default: return $urandom_range(0, 1 << 24);
            endcase
         REG_DRIVE_MIN:
            case ($urandom_range(7))
               0:       return POS_FULL;
               1:       return NEG_FULL;
               2:       return $urandom;
               default: return -32'($urandom_range(0, 1 << 24));
            endcase
         default:
            case ($urandom_range(11))
               0:       return POS_FULL;
               1:       return NEG_FULL;
               2:       return '0;
               3:       return $urandom;
               4, 5:    return spread(1 << 14);
               default: return spread(1 << 17);
            endcase
      endcase
   endfunction

   task automatic offer_sample(logic [31:0] setpoint, logic [31:0] process, pin_t pin);
      int gap;
      gap = 0;
      csr_valid <= 1'b0;
      if (idle_on) while ($urandom_range(99) < IDLE_PCT) gap++;
      pinned_q.push_back(pin);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {process, setpoint};
      do @(posedge clock); while (req_tready !== 1'b1);
      sent_count++;
   endtask

   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (checked_count != sent_count) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_valid <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      write_count++;
   endtask

   // result sink: random backpressure, one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // scoreboard: check results, predict on each accepted transaction, track register writes
   always @(posedge clock) begin
      control_out_t want, calc;
      pin_t         pin;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_q.size() == 0) begin
               $error("drive: unexpected result %h with nothing pending", rsp_tdata);
               mismatches++;
            end else begin
               want = pending_q.pop_front();
               checked_count++;
               if (rsp_tuser === 1'b1) limited_count++;
               if (rsp_tdata !== want.drive) begin
                  $error("drive: expected %h, got %h", want.drive, rsp_tdata);
                  mismatches++;
               end
               if (rsp_tuser !== want.clamped) begin
                  $error("clamped: expected %b, got %b", want.clamped, rsp_tuser);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            calc = regulate(req_tdata[DATA_WIDTH-1:0], req_tdata[2*DATA_WIDTH-1:DATA_WIDTH]);
            pin = (pinned_q.size() != 0) ? pinned_q.pop_front() : '0;
            pending_q.push_back(pin.pinned ? pin.value : calc);
         end
         if (csr_valid && csr_ready) apply_register(csr_addr, csr_wdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [31:0] setpoint, tgt, meas;
      int          reg_idx;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_write) begin
            quiesce();
            write_register(directed_rows[i].addr, directed_rows[i].value);
         end else begin
            offer_sample(directed_rows[i].target, directed_rows[i].measured,
                         {directed_rows[i].pinned, directed_rows[i].drive,
                          directed_rows[i].clamped});
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         quiesce();
         idle_on = (phase != CALM_PHASE);
         for (reg_idx = REG_STEP_TIME; reg_idx <= REG_GAIN_I; reg_idx++) begin
            if (phase == 0 || $urandom_range(1) == 1)
               write_register(reg_idx, register_value(reg_idx));
         end
         if ($urandom_range(5) == 0)
            write_register($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
         setpoint = spread(1 << 23);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (phase == SQUEEZE_PHASE && k == 8) hold_pending = 1'b1;
            case ($urandom_range(9))
               0, 1, 2, 3, 4: begin
                  tgt  = setpoint;
                  meas = setpoint + spread(1 << 17);
               end
               5: begin
                  setpoint = spread(1 << 23);
                  tgt  = setpoint;
                  meas = setpoint + spread(1 << 16);
               end
               6: begin
                  tgt  = setpoint;
                  meas = setpoint + spread(1 << 24);
               end
               7: begin
                  tgt  = $urandom;
                  meas = tgt + spread(1 << 12);
               end
               default: begin
                  tgt  = $urandom;
                  meas = $urandom;
               end
            endcase
            offer_sample(tgt, meas, '0);
         end
      end

      req_tvalid <= 1'b0;
      while (checked_count != sent_count) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (pending_q.size() != 0) begin
         $error("drive: %0d expected results never arrived", pending_q.size());
         mismatches++;
      end
      $display("Checked %0d control samples (%0d limited) across %0d register writes,",
               checked_count, limited_count, write_count);
      $display("covering zero dt, crossed limits, saturation and a long output stall.");
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/pidc_pkg.sv
rtl/pid_controller_clamped_unit.sv
bench/pid_controller_clamped_unit_test.sv
